// ===== rtl/core/signed_binary_to_decimal_ascii_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the signed binary to decimal ASCII converter
// Clocked implication checks; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SBDA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sbda assertion failed");
// next-cycle implication
`define SBDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sbda assertion failed");
`else
`define SBDA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SBDA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/sbda_pkg.sv =====
// ----------------------------------------------------------------------------
// sbda_pkg
// Shared constants and types of the signed binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sbda_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int DIGIT_W         = 4;
    localparam int CHAR_W          = 6;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    // control for every cell of the digit row
    typedef struct packed {
        logic clear;    // zero the digit
        logic dabble;   // add-3 correction, then shift one magnitude bit in
        logic shift;    // take the lower neighbor's digit
    } t_cell_ctrl;

endpackage

// ===== rtl/core/sbda_cell.sv =====
// ----------------------------------------------------------------------------
// sbda_cell
// One BCD digit of the double-dabble row: add-3 correction and shift.
// ----------------------------------------------------------------------------
module sbda_cell (
    input  logic                              i_clk,
    input  sbda_pkg::t_cell_ctrl              i_ctrl,
    input  logic                              i_bit,
    input  logic [sbda_pkg::DIGIT_W-1:0]      i_digit,
    output logic                              o_carry,
    output logic [sbda_pkg::DIGIT_W-1:0]      o_digit
);

    logic [sbda_pkg::DIGIT_W-1:0] r_digit;
    logic [sbda_pkg::DIGIT_W-1:0] n_digit;
    logic [sbda_pkg::DIGIT_W-1:0] w_adj;

    assign w_adj = (r_digit >= sbda_pkg::DIGIT_W'(5)) ? r_digit + sbda_pkg::DIGIT_W'(3)
                                                      : r_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_ctrl.clear) begin
            n_digit = '0;
        end else if (i_ctrl.dabble) begin
            n_digit = {w_adj[sbda_pkg::DIGIT_W-2:0], i_bit};
        end else if (i_ctrl.shift) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_carry = w_adj[sbda_pkg::DIGIT_W-1];
    assign o_digit = r_digit;

endmodule

// ===== rtl/core/sbda_row.sv =====
// ----------------------------------------------------------------------------
// sbda_row
// Row of BCD digit cells; the top cell holds the most significant digit.
// ----------------------------------------------------------------------------
module sbda_row #(
    parameter int NDIGITS = 10
) (
    input  logic                              i_clk,
    input  sbda_pkg::t_cell_ctrl              i_ctrl,
    input  logic                              i_bit,
    output logic [sbda_pkg::DIGIT_W-1:0]      o_top
);

    logic                         w_carry [NDIGITS];
    logic [sbda_pkg::DIGIT_W-1:0] w_digit [NDIGITS];

    for (genvar g = 0; g < NDIGITS; g++) begin : g_cell
        logic                         w_bit_in;
        logic [sbda_pkg::DIGIT_W-1:0] w_digit_in;

        if (g == 0) begin : g_first
            assign w_bit_in   = i_bit;
            assign w_digit_in = '0;
        end else begin : g_next
            assign w_bit_in   = w_carry[g-1];
            assign w_digit_in = w_digit[g-1];
        end

        sbda_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (i_ctrl),
            .i_bit   (w_bit_in),
            .i_digit (w_digit_in),
            .o_carry (w_carry[g]),
            .o_digit (w_digit[g])
        );
    end

    // the top carry stays low: the row is sized for the full magnitude
    assign o_top = w_digit[NDIGITS-1] | {sbda_pkg::DIGIT_W{1'b0 & w_carry[NDIGITS-1]}};

endmodule

// ===== rtl/core/signed_binary_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// Signed integer in, decimal ASCII text out, one character at a time.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry i_value, a two's complement
// integer of VALUE_WIDTH bits. Output channel: o_out_valid / i_out_stall
// carry o_character ('-' or '0'..'9') and o_last, high on the final
// character of each number. Leading zeros are dropped; zero prints as '0'.
// Operation: the magnitude enters the row of BCD digit cells one bit per
// cycle, then leading zero digits are shifted out at one per cycle, then
// the sign and digits leave one per cycle while the output is not stalled.
// Per number, the bit-serial dabble through the digit row takes most of
// the time. The first character is loaded once the leading zeros are
// skipped; for a negative number it is the '-'.
// One number is converted at a time; o_in_stall is low only when idle.
// An output stall holds the current character and, while characters are being emitted, pauses the digit row.
// Reset (synchronous, active low) returns to idle and drops any pending
// output; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "signed_binary_to_decimal_ascii_macros.svh"

module signed_binary_to_decimal_ascii #(
    parameter int VALUE_WIDTH = sbda_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic signed [VALUE_WIDTH-1:0]   i_value,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [sbda_pkg::CHAR_W-1:0]     o_character,
    output logic                            o_last
);

    // digits of 2^VALUE_WIDTH, enough for any magnitude
    localparam int NDIGITS = (VALUE_WIDTH * 77) / 256 + 1;
    localparam int BCNT_W  = $clog2(VALUE_WIDTH + 1);
    localparam int LEFT_W  = $clog2(NDIGITS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SKIP = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state                        r_state, n_state;
    logic [VALUE_WIDTH-1:0]        r_mag, n_mag;
    logic                          r_neg, n_neg;
    logic [BCNT_W-1:0]             r_bcnt, n_bcnt;
    logic [LEFT_W-1:0]             r_left, n_left;
    logic                          r_o_valid, n_o_valid;
    logic [sbda_pkg::CHAR_W-1:0]   r_o_char, n_o_char;
    logic                          r_o_last, n_o_last;

    logic                          w_accept;
    logic                          w_load_ok;
    logic [VALUE_WIDTH-1:0]        w_uvalue;
    logic [sbda_pkg::DIGIT_W-1:0]  w_top;
    sbda_pkg::t_cell_ctrl          w_ctrl;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_load_ok  = !r_o_valid || !i_out_stall;
    assign w_uvalue   = $unsigned(i_value);

    sbda_row #(
        .NDIGITS (NDIGITS)
    ) u_row (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_bit  (r_mag[VALUE_WIDTH-1]),
        .o_top  (w_top)
    );

    always_comb begin
        n_state   = r_state;
        n_mag     = r_mag;
        n_neg     = r_neg;
        n_bcnt    = r_bcnt;
        n_left    = r_left;
        n_o_valid = r_o_valid;
        n_o_char  = r_o_char;
        n_o_last  = r_o_last;
        w_ctrl    = '0;

        if (r_o_valid && !i_out_stall) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_ctrl.clear = 1'b1;
                    n_neg   = w_uvalue[VALUE_WIDTH-1];
                    n_mag   = w_uvalue[VALUE_WIDTH-1] ? (~w_uvalue) + VALUE_WIDTH'(1)
                                                      : w_uvalue;
                    n_bcnt  = BCNT_W'(VALUE_WIDTH);
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                w_ctrl.dabble = 1'b1;
                n_mag  = r_mag << 1;
                n_bcnt = r_bcnt - BCNT_W'(1);
                if (r_bcnt == BCNT_W'(1)) begin
                    n_left  = LEFT_W'(NDIGITS);
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                // drop leading zeros, keep at least one digit
                if (w_top == '0 && r_left != LEFT_W'(1)) begin
                    w_ctrl.shift = 1'b1;
                    n_left = r_left - LEFT_W'(1);
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_load_ok) begin
                    n_o_valid = 1'b1;
                    if (r_neg) begin
                        n_o_char = sbda_pkg::CHAR_MINUS;
                        n_o_last = 1'b0;
                        n_neg    = 1'b0;
                    end else begin
                        w_ctrl.shift = 1'b1;
                        n_o_char = sbda_pkg::CHAR_ZERO
                                   + {{(sbda_pkg::CHAR_W-sbda_pkg::DIGIT_W){1'b0}}, w_top};
                        n_o_last = (r_left == LEFT_W'(1));
                        n_left   = r_left - LEFT_W'(1);
                        if (r_left == LEFT_W'(1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_bcnt   <= n_bcnt;
        r_left   <= n_left;
        r_o_char <= n_o_char;
        r_o_last <= n_o_last;
    end

    assign o_out_valid = r_o_valid;
    assign o_character = r_o_char;
    assign o_last      = r_o_last;

    `SBDA_ASSERT_NOW(a_char_range, i_clk, i_rst_n,
        r_o_valid && r_o_char != sbda_pkg::CHAR_MINUS,
        r_o_char >= sbda_pkg::CHAR_ZERO && r_o_char <= sbda_pkg::CHAR_NINE)
    `SBDA_ASSERT_NOW(a_minus_not_last, i_clk, i_rst_n,
        r_o_valid && r_o_char == sbda_pkg::CHAR_MINUS, !r_o_last)
    `SBDA_ASSERT_NEXT(a_accept_conv, i_clk, i_rst_n, w_accept, r_state == S_CONV)
    `SBDA_ASSERT_NOW(a_left_nonzero, i_clk, i_rst_n,
        r_state == S_SKIP || r_state == S_EMIT, r_left != '0)
    `SBDA_ASSERT_NEXT(a_last_to_idle, i_clk, i_rst_n,
        r_state == S_EMIT && w_load_ok && !r_neg && r_left == LEFT_W'(1),
        r_state == S_IDLE && r_o_valid && r_o_last)

endmodule
